[hdl/psi_pkg.sv]
package psi_pkg;

    localparam int unsigned Q_W         = 32;
    localparam int unsigned LIFE_W      = 9;
    localparam int unsigned CFG_W       = 9;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned S_DATA_W    = 64;
    localparam int unsigned S_USER_W    = 2;
    localparam int unsigned M_DATA_W    = 152;
    localparam int unsigned M_USER_W    = 1;

    localparam int unsigned LIFE_START  = 255;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [CFG_W-1:0] CFG_FULL = 9'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd1;

    localparam logic [S_USER_W-1:0] REQ_SET_POS = 2'd0;
    localparam logic [S_USER_W-1:0] REQ_SET_VEL = 2'd1;
    localparam logic [S_USER_W-1:0] REQ_FORCE   = 2'd2;
    localparam logic [S_USER_W-1:0] REQ_STEP    = 2'd3;

    typedef enum logic [1:0] {
        OP_SET_POS,
        OP_SET_VEL,
        OP_FORCE,
        OP_STEP
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS,
        ST_HUE0,
        ST_HUE1,
        ST_SECT,
        ST_MUL0,
        ST_MUL1,
        ST_DIV0,
        ST_OUT
    } t_state;

endpackage

[hdl/particle_state_integrator.sv]
// Particle state integrator: one particle driven by one request word at a time
// (set position, set velocity, apply force, Euler update step); every request
// returns one word with position, velocity, an HSV-derived RGB color of the
// remaining lifespan and a dead flag. Requests enter a register stage and a
// QUEUE_DEPTH-entry queue, so the input keeps accepting while the back unit
// works. The back unit handles one request at a time: an update step first adds
// velocity to position, then each request runs the hue, sector, multiply and
// reciprocal-divide states; the finished word waits in an output register while
// the next request starts. The user must write saturation and brightness through
// the config port only while idle; the block itself does not enforce it.
module particle_state_integrator #(
    parameter int unsigned QUEUE_DEPTH = psi_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [psi_pkg::S_DATA_W-1:0]   s_tdata,   // x_value, y_value
    input  logic [psi_pkg::S_USER_W-1:0]   s_tuser,   // req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [psi_pkg::M_DATA_W-1:0]   m_tdata,   // pos_x, pos_y, vel_x, vel_y, r, g, b
    output logic [psi_pkg::M_USER_W-1:0]   m_tuser,   // dead
    input  logic                           i_cfg_we,
    input  logic [psi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psi_pkg::CFG_W-1:0]      i_cfg_wdata
);

    logic [psi_pkg::CFG_W-1:0] r_saturation;
    logic [psi_pkg::CFG_W-1:0] r_brightness;

    logic          push_valid, push_ready;
    psi_pkg::t_cmd push_cmd;
    logic          pop_valid, pop;
    psi_pkg::t_cmd pop_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saturation <= psi_pkg::CFG_FULL;
            r_brightness <= psi_pkg::CFG_FULL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                psi_pkg::CFG_SATURATION: r_saturation <= i_cfg_wdata;
                psi_pkg::CFG_BRIGHTNESS: r_brightness <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    psi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_cmd   (push_cmd)
    );

    psi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_cmd    (pop_cmd)
    );

    psi_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_saturation (r_saturation),
        .i_brightness (r_brightness),
        .i_pop_valid  (pop_valid),
        .o_pop        (pop),
        .i_pop_cmd    (pop_cmd),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

[hdl/psi_front.sv]
module psi_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [psi_pkg::S_DATA_W-1:0]  s_tdata,   // x_value, y_value
    input  logic [psi_pkg::S_USER_W-1:0]  s_tuser,   // req_type
    output logic                          o_push_valid,
    input  logic                          i_push_ready,
    output psi_pkg::t_cmd                 o_push_cmd
);

    logic          r_valid;
    psi_pkg::t_cmd r_cmd;
    psi_pkg::t_cmd n_cmd;
    logic          accept;

    assign s_tready     = !r_valid || i_push_ready;
    assign accept       = s_tvalid && s_tready;
    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

    always_comb begin
        n_cmd.x = $signed(s_tdata[psi_pkg::Q_W-1:0]);
        n_cmd.y = $signed(s_tdata[2*psi_pkg::Q_W-1:psi_pkg::Q_W]);
        unique case (s_tuser)
            psi_pkg::REQ_SET_POS: n_cmd.op = psi_pkg::OP_SET_POS;
            psi_pkg::REQ_SET_VEL: n_cmd.op = psi_pkg::OP_SET_VEL;
            psi_pkg::REQ_FORCE:   n_cmd.op = psi_pkg::OP_FORCE;
            default:              n_cmd.op = psi_pkg::OP_STEP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !i_push_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

[hdl/psi_queue.sv]
module psi_queue #(
    parameter int unsigned DEPTH = psi_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_push_ready,
    input  psi_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop,
    output psi_pkg::t_cmd o_pop_cmd
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    psi_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

[hdl/psi_back.sv]
module psi_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [psi_pkg::CFG_W-1:0]     i_saturation,
    input  logic [psi_pkg::CFG_W-1:0]     i_brightness,
    input  logic                          i_pop_valid,
    output logic                          o_pop,
    input  psi_pkg::t_cmd                 i_pop_cmd,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [psi_pkg::M_DATA_W-1:0]  m_tdata,   // pos_x, pos_y, vel_x, vel_y, r, g, b
    output logic [psi_pkg::M_USER_W-1:0]  m_tuser    // dead
);

    localparam int unsigned QW = psi_pkg::Q_W;

    function automatic logic signed [QW-1:0] sat_add(
        input logic signed [QW-1:0] a,
        input logic signed [QW-1:0] b
    );
        logic [QW:0] s;
        s = {a[QW-1], a} + {b[QW-1], b};
        if (s[QW] != s[QW-1]) begin
            return s[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        end
        return s[QW-1:0];
    endfunction

    psi_pkg::t_state r_state, n_state;
    logic            load_out;

    logic signed [QW-1:0] r_pos_x, r_pos_y, r_vel_x, r_vel_y, r_acc_x, r_acc_y;
    logic signed [psi_pkg::LIFE_W-1:0] r_life;

    // hue and color pipeline
    logic [12:0] r_hy;
    logic [8:0]  r_hq0;
    logic        r_neg;
    logic [8:0]  r_hue;
    logic [2:0]  r_sector;
    logic [5:0]  r_rem;
    logic [15:0] r_a;
    logic [8:0]  r_bp;
    logic [13:0] r_bq, r_bt;
    logic [24:0] r_np;
    logic [29:0] r_nq, r_nt;
    logic [13:0] r_hq, r_ht;
    logic [7:0]  r_dq0, r_dt0;

    logic [12:0] hy;
    logic [24:0] hprod;
    logic [12:0] hrem;
    logic [8:0]  hue;
    logic [8:0]  base;
    logic [2:0]  sector;
    logic [8:0]  sc, vc;
    logic [14:0] m_q, m_t;
    logic [28:0] dprod_q, dprod_t;
    logic [13:0] rq, rt;
    logic [7:0]  cq, ct, cp, cv;
    logic [7:0]  red, green, blue;

    logic                        r_m_valid;
    logic [psi_pkg::M_DATA_W-1:0] r_m_data;
    logic [psi_pkg::M_USER_W-1:0] r_m_user;

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_user;

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            psi_pkg::ST_IDLE: begin
                if (i_pop_valid) begin
                    o_pop   = 1'b1;
                    n_state = (i_pop_cmd.op == psi_pkg::OP_STEP) ?
                              psi_pkg::ST_POS : psi_pkg::ST_HUE0;
                end
            end
            psi_pkg::ST_POS:  n_state = psi_pkg::ST_HUE0;
            psi_pkg::ST_HUE0: n_state = psi_pkg::ST_HUE1;
            psi_pkg::ST_HUE1: n_state = psi_pkg::ST_SECT;
            psi_pkg::ST_SECT: n_state = psi_pkg::ST_MUL0;
            psi_pkg::ST_MUL0: n_state = psi_pkg::ST_MUL1;
            psi_pkg::ST_MUL1: n_state = psi_pkg::ST_DIV0;
            psi_pkg::ST_DIV0: n_state = psi_pkg::ST_OUT;
            psi_pkg::ST_OUT: begin
                if (!r_m_valid || m_tready) begin
                    load_out = 1'b1;
                    n_state  = psi_pkg::ST_IDLE;
                end
            end
            default: n_state = psi_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // particle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_vel_x <= '0;
            r_vel_y <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_life  <= psi_pkg::LIFE_W'(psi_pkg::LIFE_START);
        end else if (o_pop) begin
            unique case (i_pop_cmd.op)
                psi_pkg::OP_SET_POS: begin
                    r_pos_x <= i_pop_cmd.x;
                    r_pos_y <= i_pop_cmd.y;
                end
                psi_pkg::OP_SET_VEL: begin
                    r_vel_x <= i_pop_cmd.x;
                    r_vel_y <= i_pop_cmd.y;
                end
                psi_pkg::OP_FORCE: begin
                    r_acc_x <= sat_add(r_acc_x, i_pop_cmd.x);
                    r_acc_y <= sat_add(r_acc_y, i_pop_cmd.y);
                end
                default: begin
                    r_vel_x <= sat_add(r_vel_x, r_acc_x);
                    r_vel_y <= sat_add(r_vel_y, r_acc_y);
                    r_acc_x <= '0;
                    r_acc_y <= '0;
                    if (!r_life[psi_pkg::LIFE_W-1]) begin
                        r_life <= r_life - 1'b1;
                    end
                end
            endcase
        end else if (r_state == psi_pkg::ST_POS) begin
            r_pos_x <= sat_add(r_pos_x, r_vel_x);
            r_pos_y <= sat_add(r_pos_y, r_vel_y);
        end
    end

    // hue = floor(24*life/17) via reciprocal, then sector split and HSV terms
    always_comb begin
        hy      = 13'({r_life[7:0], 4'b0}) + 13'({r_life[7:0], 3'b0});
        hprod   = 25'(hy) * 25'(12'd3855);
        hrem    = 13'(r_hy - 13'(17) * 13'(r_hq0));
        hue     = r_hq0 + 9'((hrem >= 13'd17) ? 1 : 0);
        if (r_neg) begin
            hue = 9'd359;
        end else if (hue == 9'd360) begin
            hue = 9'd0;
        end
        priority if (r_hue >= 9'd300) begin
            sector = 3'd5; base = 9'd300;
        end else if (r_hue >= 9'd240) begin
            sector = 3'd4; base = 9'd240;
        end else if (r_hue >= 9'd180) begin
            sector = 3'd3; base = 9'd180;
        end else if (r_hue >= 9'd120) begin
            sector = 3'd2; base = 9'd120;
        end else if (r_hue >= 9'd60) begin
            sector = 3'd1; base = 9'd60;
        end else begin
            sector = 3'd0; base = 9'd0;
        end
        sc      = (i_saturation > psi_pkg::CFG_FULL) ? psi_pkg::CFG_FULL : i_saturation;
        vc      = (i_brightness > psi_pkg::CFG_FULL) ? psi_pkg::CFG_FULL : i_brightness;
        m_q     = 15'(sc) * 15'(r_rem);
        m_t     = 15'(sc) * 15'(6'(6'd60 - r_rem));
        dprod_q = 29'(r_nq[29:16]) * 29'(15'd17476);
        dprod_t = 29'(r_nt[29:16]) * 29'(15'd17476);
        rq      = 14'(r_hq - 14'(60) * 14'(r_dq0));
        rt      = 14'(r_ht - 14'(60) * 14'(r_dt0));
        cq      = r_dq0 + 8'((rq >= 14'd60) ? 1 : 0);
        ct      = r_dt0 + 8'((rt >= 14'd60) ? 1 : 0);
        cp      = r_np[23:16];
        cv      = r_a[15:8];
        unique case (r_sector)
            3'd1:    begin red = cq; green = cv; blue = cp; end
            3'd2:    begin red = cp; green = cv; blue = ct; end
            3'd3:    begin red = cp; green = cq; blue = cv; end
            3'd4:    begin red = ct; green = cp; blue = cv; end
            3'd5:    begin red = cv; green = cp; blue = cq; end
            default: begin red = cv; green = ct; blue = cp; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            psi_pkg::ST_HUE0: begin
                r_hy  <= hy;
                r_hq0 <= hprod[24:16];
                r_neg <= r_life[psi_pkg::LIFE_W-1];
            end
            psi_pkg::ST_HUE1: begin
                r_hue <= hue;
            end
            psi_pkg::ST_SECT: begin
                r_sector <= sector;
                r_rem    <= 6'(r_hue - base);
            end
            psi_pkg::ST_MUL0: begin
                r_a  <= 16'(16'(vc) * 16'(8'd255));
                r_bp <= 9'(psi_pkg::CFG_FULL - sc);
                r_bq <= 14'(15'd15360 - m_q);
                r_bt <= 14'(15'd15360 - m_t);
            end
            psi_pkg::ST_MUL1: begin
                r_np <= 25'(r_a) * 25'(r_bp);
                r_nq <= 30'(r_a) * 30'(r_bq);
                r_nt <= 30'(r_a) * 30'(r_bt);
            end
            psi_pkg::ST_DIV0: begin
                r_hq  <= r_nq[29:16];
                r_ht  <= r_nt[29:16];
                r_dq0 <= dprod_q[27:20];
                r_dt0 <= dprod_t[27:20];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_m_data <= {blue, green, red, r_vel_y, r_vel_x, r_pos_y, r_pos_x};
            r_m_user <= r_life[psi_pkg::LIFE_W-1];
        end
    end

endmodule

[sim/particle_state_integrator_tb.sv]
module particle_state_integrator_tb;

    localparam logic [31:0] MAXQ = 32'h7fff_ffff;
    localparam logic [31:0] MINQ = 32'h8000_0000;
    localparam logic [31:0] ONES = 32'hffff_ffff;

    localparam logic [psi_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [psi_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int DRAIN_CYCLES  = 30;
    localparam int STALL_CYCLES  = 300;
    localparam int STALL_AT_WORD = 250;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int PHASES        = 6;
    localparam int PHASE_WORDS   = 170;
    localparam int IDLE_PCT      = 11;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        dead;
    } t_result;

    typedef struct packed {
        psi_pkg::t_op op;
        logic [31:0]  x;
        logic [31:0]  y;
        logic         typed;
        t_result      want;
    } t_row;

    localparam t_result NO_WANT   = '0;
    localparam t_result AT_ORIGIN = '{32'h0, 32'h0, 32'h0, 32'h0, 8'hff, 8'h00, 8'h00, 1'b0};
    localparam t_result AT_CORNER = '{MAXQ, MINQ, 32'h0, 32'h0, 8'hff, 8'h00, 8'h00, 1'b0};
    localparam t_result CORNER_VEL = '{MAXQ, MINQ, MINQ, MAXQ, 8'hff, 8'h00, 8'h00, 1'b0};

    localparam int N_DIRECTED = 21;
    localparam t_row DIRECTED [0:N_DIRECTED-1] = '{
        '{psi_pkg::OP_FORCE,   32'h0,         32'h0,         1'b1, AT_ORIGIN},
        '{psi_pkg::OP_SET_POS, MAXQ,          MINQ,          1'b1, AT_CORNER},
        '{psi_pkg::OP_SET_VEL, MINQ,          MAXQ,          1'b1, CORNER_VEL},
        '{psi_pkg::OP_FORCE,   MAXQ,          MINQ,          1'b1, CORNER_VEL},
        '{psi_pkg::OP_FORCE,   MAXQ,          MINQ,          1'b1, CORNER_VEL},
        '{psi_pkg::OP_STEP,    ONES,          ONES,          1'b0, NO_WANT},
        '{psi_pkg::OP_SET_VEL, MAXQ,          MAXQ,          1'b0, NO_WANT},
        '{psi_pkg::OP_FORCE,   32'h1,         32'h1,         1'b0, NO_WANT},
        '{psi_pkg::OP_STEP,    32'h0,         32'h0,         1'b0, NO_WANT},
        '{psi_pkg::OP_SET_POS, MINQ,          MINQ,          1'b0, NO_WANT},
        '{psi_pkg::OP_SET_VEL, MINQ,          MINQ,          1'b0, NO_WANT},
        '{psi_pkg::OP_FORCE,   ONES,          ONES,          1'b0, NO_WANT},
        '{psi_pkg::OP_STEP,    MAXQ,          MINQ,          1'b0, NO_WANT},
        '{psi_pkg::OP_SET_POS, 32'h0001_0000, 32'hffff_0000, 1'b0, NO_WANT},
        '{psi_pkg::OP_SET_VEL, 32'h0000_8000, 32'hffff_8000, 1'b0, NO_WANT},
        '{psi_pkg::OP_FORCE,   32'haaaa_aaaa, 32'h5555_5555, 1'b0, NO_WANT},
        '{psi_pkg::OP_FORCE,   32'h5555_5555, 32'haaaa_aaaa, 1'b0, NO_WANT},
        '{psi_pkg::OP_STEP,    32'h0,         32'h0,         1'b0, NO_WANT},
        '{psi_pkg::OP_STEP,    32'h0,         32'h0,         1'b0, NO_WANT},
        '{psi_pkg::OP_SET_VEL, 32'h0,         32'h0,         1'b0, NO_WANT},
        '{psi_pkg::OP_STEP,    32'h0,         32'h0,         1'b0, NO_WANT}
    };

    localparam logic [psi_pkg::CFG_W-1:0] SAT_PLAN [0:PHASES-1] =
        '{9'd256, 9'd0, 9'd511, 9'd128, 9'd257, 9'd1};
    localparam logic [psi_pkg::CFG_W-1:0] BRI_PLAN [0:PHASES-1] =
        '{9'd256, 9'd256, 9'd0, 9'd200, 9'd511, 9'd37};

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [psi_pkg::S_DATA_W-1:0]    s_tdata;
    logic [psi_pkg::S_USER_W-1:0]    s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [psi_pkg::M_DATA_W-1:0]    m_tdata;
    logic [psi_pkg::M_USER_W-1:0]    m_tuser;
    logic                            i_cfg_we;
    logic [psi_pkg::CFG_IDX_W-1:0]   i_cfg_idx;
    logic [psi_pkg::CFG_W-1:0]       i_cfg_wdata;

    logic signed [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
    int                 life;
    int                 sat_reg, bri_reg;

    t_result expected_states [$];
    int      fail_count;
    int      words_sent;
    bit      tx_idle_on;
    bit      rx_idle_on;

    particle_state_integrator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] add_clamped(logic signed [31:0] a,
                                                       logic signed [31:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > longint'(32'sh7fff_ffff)) return MAXQ;
        if (s < -longint'(64'h8000_0000)) return MINQ;
        return s[31:0];
    endfunction

    function automatic logic [23:0] hsv_of_life(int lifetime);
        int                hue;
        longint unsigned   s, v, sector, rem, cv, cp, cq, ct, r, g, b;
        hue = (360 * lifetime) / 255;
        hue = hue % 360;
        if (hue < 0) hue += 360;
        s = longint'((sat_reg > 256) ? 256 : sat_reg);
        v = longint'((bri_reg > 256) ? 256 : bri_reg);
        sector = longint'(hue / 60);
        rem = longint'(hue % 60);
        cv = (255 * v) / 256;
        cp = (255 * v * (256 - s)) / 65536;
        cq = (255 * v * (15360 - s * rem)) / 3932160;
        ct = (255 * v * (15360 - s * (60 - rem))) / 3932160;
        case (sector)
            1: begin r = cq; g = cv; b = cp; end
            2: begin r = cp; g = cv; b = ct; end
            3: begin r = cp; g = cq; b = cv; end
            4: begin r = ct; g = cp; b = cv; end
            5: begin r = cv; g = cp; b = cq; end
            default: begin r = cv; g = ct; b = cp; end
        endcase
        return {b[7:0], g[7:0], r[7:0]};
    endfunction

    function automatic t_result integrate(psi_pkg::t_op op, logic signed [31:0] x,
                                          logic signed [31:0] y);
        t_result     res;
        logic [23:0] rgb;
        case (op)
            psi_pkg::OP_SET_POS: begin
                pos_x = x;
                pos_y = y;
            end
            psi_pkg::OP_SET_VEL: begin
                vel_x = x;
                vel_y = y;
            end
            psi_pkg::OP_FORCE: begin
                acc_x = add_clamped(acc_x, x);
                acc_y = add_clamped(acc_y, y);
            end
            default: begin
                vel_x = add_clamped(vel_x, acc_x);
                vel_y = add_clamped(vel_y, acc_y);
                pos_x = add_clamped(pos_x, vel_x);
                pos_y = add_clamped(pos_y, vel_y);
                acc_x = '0;
                acc_y = '0;
                if (life > -1) life -= 1;
            end
        endcase
        rgb = hsv_of_life(life);
        res.pos_x = pos_x;
        res.pos_y = pos_y;
        res.vel_x = vel_x;
        res.vel_y = vel_y;
        res.red   = rgb[7:0];
        res.green = rgb[15:8];
        res.blue  = rgb[23:16];
        res.dead  = (life < 0);
        return res;
    endfunction

    function automatic logic [31:0] draw_q();
        logic [31:0] mag;
        mag = $urandom_range(32'h0004_0000);
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5: return ($urandom_range(1) != 0) ? mag : -mag;
            6: return MAXQ;
            7: return MINQ;
            8: return 32'h0;
            default: return ($urandom_range(1) != 0) ? MAXQ - mag : MINQ + mag;
        endcase
    endfunction

    task automatic send_request(psi_pkg::t_op op, logic [31:0] x, logic [31:0] y,
                                logic typed, t_result want);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tuser  <= op;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        words_sent++;
        if (typed) begin
            void'(integrate(op, x, y));
            expected_states.push_back(want);
        end else begin
            expected_states.push_back(integrate(op, x, y));
        end
    endtask

    task automatic program_reg(logic [psi_pkg::CFG_IDX_W-1:0] idx,
                               logic [psi_pkg::CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == psi_pkg::CFG_SATURATION) sat_reg = int'(val);
        else if (idx == psi_pkg::CFG_BRIGHTNESS) bri_reg = int'(val);
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
        end
    endtask

    initial begin
        t_result want;
        int      stall_left;
        bit      stall_done;
        stall_left = 0;
        stall_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_tvalid && m_tready) begin
                if (expected_states.size() == 0) begin
                    fail_count++;
                    $display("%0t: word with nothing expected, actual %h dead %b",
                             $realtime, m_tdata, m_tuser[0]);
                end else begin
                    want = expected_states.pop_front();
                    compare_field("pos_x", want.pos_x, m_tdata[31:0]);
                    compare_field("pos_y", want.pos_y, m_tdata[63:32]);
                    compare_field("vel_x", want.vel_x, m_tdata[95:64]);
                    compare_field("vel_y", want.vel_y, m_tdata[127:96]);
                    compare_field("red",   32'(want.red),   32'(m_tdata[135:128]));
                    compare_field("green", 32'(want.green), 32'(m_tdata[143:136]));
                    compare_field("blue",  32'(want.blue),  32'(m_tdata[151:144]));
                    compare_field("dead",  32'(want.dead),  32'(m_tuser[0]));
                end
            end
            if (!stall_done && words_sent >= STALL_AT_WORD) begin
                stall_done = 1'b1;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(rx_idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_MAX) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int           k;
        int           ph;
        int           pick;
        psi_pkg::t_op op;
        fail_count  = 0;
        words_sent  = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        pos_x = '0; pos_y = '0; vel_x = '0; vel_y = '0; acc_x = '0; acc_y = '0;
        life = int'(psi_pkg::LIFE_START);
        sat_reg = 256;
        bri_reg = 256;
        i_rst_n     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_wdata <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIRECTED; k++)
            send_request(DIRECTED[k].op, DIRECTED[k].x, DIRECTED[k].y,
                         DIRECTED[k].typed, DIRECTED[k].want);

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                s_tvalid <= 1'b0;
                while (expected_states.size() != 0) @(posedge i_clk);
                repeat (DRAIN_CYCLES) @(posedge i_clk);
                program_reg(psi_pkg::CFG_SATURATION, SAT_PLAN[ph]);
                program_reg(psi_pkg::CFG_BRIGHTNESS, BRI_PLAN[ph]);
                if (ph == 4) begin
                    program_reg(CFG_SPARE_A, psi_pkg::CFG_W'($urandom));
                    program_reg(CFG_SPARE_B, psi_pkg::CFG_W'($urandom));
                end
                i_cfg_we <= 1'b0;
            end
            // keep one phase free of random gaps on both sides
            tx_idle_on = (ph != 2);
            rx_idle_on = (ph != 2);
            for (k = 0; k < PHASE_WORDS; k++) begin
                pick = $urandom_range(99);
                if (pick < 15) op = psi_pkg::OP_SET_POS;
                else if (pick < 35) op = psi_pkg::OP_SET_VEL;
                else if (pick < 65) op = psi_pkg::OP_FORCE;
                else op = psi_pkg::OP_STEP;
                send_request(op, draw_q(), draw_q(), 1'b0, NO_WANT);
            end
        end

        s_tvalid <= 1'b0;
        while (expected_states.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
